// ----- rtl/wfa_pkg.sv -----
// Shared types, constants and helper functions for the window function block.
// Used by wfa_front, wfa_back and window_function_apply_top; no dependencies.
package wfa_pkg;

	// Sizes of the stream and of the phase arithmetic.
	localparam int PhaseBits   = 12;
	localparam int MaxLength   = 4096;
	localparam int IndexBits   = 12;
	localparam int LenBits     = 13;
	localparam int SampleBits  = 16;
	localparam int CoefBits    = 16;
	localparam int CoefOne     = 32768;
	localparam int QuarterLen  = 1 << (PhaseBits - 2);
	localparam int RomAddrBits = $clog2(QuarterLen + 1);
	localparam int AccBits     = 34;
	localparam int ScaledBits  = 33;
	localparam int RoundHalf   = 16384;

	// Angle of one phase step in radians.
	localparam real PhaseStep  = 2.0 * 3.14159265358979323846 / real'(1 << PhaseBits);

	// Queue depths between the parts and at the result side.
	localparam int ItemDepth   = 4;
	localparam int ItemPtrBits = $clog2(ItemDepth);
	localparam int ItemCntBits = $clog2(ItemDepth + 1);
	localparam int ResDepth    = 2;
	localparam int ResPtrBits  = $clog2(ResDepth);
	localparam int ResCntBits  = $clog2(ResDepth + 1);

	// Configuration port.
	localparam int CfgIdxBits  = 2;
	localparam int CfgDataBits = 13;
	localparam logic [CfgIdxBits-1:0] RegWindowType   = 2'd0;
	localparam logic [CfgIdxBits-1:0] RegWindowLength = 2'd1;
	localparam logic [LenBits-1:0]    LengthReset     = 13'd1024;

	typedef enum logic [1:0] {
		WinBoxcar   = 2'd0,
		WinHann     = 2'd1,
		WinHamming  = 2'd2,
		WinBlackman = 2'd3
	} win_type_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic signed [SampleBits-1:0] sample;
		logic [IndexBits-1:0]         k;
		logic [IndexBits-1:0]         d;
		logic                         last;
		win_type_t                    wtype;
	} item_t;

	// Head of the item queue as the back sees it.
	typedef struct packed {
		logic  avail;
		item_t item;
	} item_q_t;

	// One finished result.
	typedef struct packed {
		logic signed [SampleBits-1:0] windowed_sample;
		logic [CoefBits-1:0]          coefficient;
		logic                         last;
	} result_t;

	typedef logic [CoefBits-1:0] cos_rom_t [QuarterLen+1];

	// Quarter-wave cosine in Q15, rounded half away from zero.
	function automatic cos_rom_t build_cos_rom();
		cos_rom_t rom;
		real      x;
		int       v;
		for (int p = 0; p <= QuarterLen; p++) begin
			x = 32768.0 * $cos(PhaseStep * real'(p));
			v = int'(x);
			if (v < 0) begin
				v = 0;
			end
			rom[p] = CoefBits'(v);
		end
		return rom;
	endfunction

	// Constant term of the window, Q15.
	function automatic logic [CoefBits-1:0] coef_a0(win_type_t t);
		unique case (t)
			WinHann:     return 16'd16384;
			WinHamming:  return 16'd17695;
			WinBlackman: return 16'd13763;
			default:     return 16'd32768;
		endcase
	endfunction

	// Weight of the first cosine, Q15 (subtracted).
	function automatic logic [CoefBits-1:0] coef_a1(win_type_t t);
		unique case (t)
			WinHann:     return 16'd16384;
			WinHamming:  return 16'd15073;
			WinBlackman: return 16'd16384;
			default:     return 16'd0;
		endcase
	endfunction

	// Weight of the second cosine, Q15 (added).
	function automatic logic [CoefBits-1:0] coef_a2(win_type_t t);
		unique case (t)
			WinBlackman: return 16'd2621;
			default:     return 16'd0;
		endcase
	endfunction

endpackage

// ----- rtl/window_function_apply_top.sv -----
// Window function block: multiplies a Q15 sample stream by a boxcar, Hann,
// Hamming or Blackman window. Depends on wfa_pkg, wfa_front and wfa_back.
//
// Usage:
//   Input channel: an item (sample) is taken at a clock edge with push high and
//   full low. Results leave as a queue: while empty is low the oldest result is
//   on windowed_sample, coefficient and last; pop high at an edge takes it.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 window type,
//   1 window length) at the clock edge, effective for the next item; other
//   indexes are ignored. Write only while no items are in flight.
//   Timing: the front accepts one item per cycle while full is low into a
//   four-entry item queue. The back handles one item at a time: it takes the
//   item, runs the bit-serial phase divider, then lookup, multiply, coefficient,
//   scale and deliver, and takes no new item until the last one is delivered.
//   A stalled receiver fills the two-entry result queue, then the back halts,
//   then the item queue fills and full rises. No item is ever dropped.
//   Reset: arst_n low clears the queues and the frame index, selects boxcar and
//   sets the window length to 1024.
module window_function_apply_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [wfa_pkg::SampleBits-1:0] sample,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [wfa_pkg::SampleBits-1:0] windowed_sample,
	output logic [wfa_pkg::CoefBits-1:0]          coefficient,
	output logic                                  last,
	input  logic                                  cfg_we,
	input  logic [wfa_pkg::CfgIdxBits-1:0]        cfg_index,
	input  logic [wfa_pkg::CfgDataBits-1:0]       cfg_data
);

	wfa_pkg::item_q_t item_head;
	logic             item_pop;

	// Front: configuration, index tracking and item queue.
	wfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_out     (item_head),
		.q_pop     (item_pop)
	);

	// Back: phase, coefficient, scaling and result queue.
	wfa_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_in            (item_head),
		.q_pop           (item_pop),
		.empty           (empty),
		.pop             (pop),
		.windowed_sample (windowed_sample),
		.coefficient     (coefficient),
		.last            (last)
	);

endmodule

// ----- rtl/wfa_front.sv -----
// Front part of the window block: configuration registers, running index and
// the short item queue toward the back part. Depends on wfa_pkg.
module wfa_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [wfa_pkg::SampleBits-1:0] sample,
	input  logic                                cfg_we,
	input  logic [wfa_pkg::CfgIdxBits-1:0]      cfg_index,
	input  logic [wfa_pkg::CfgDataBits-1:0]     cfg_data,
	output wfa_pkg::item_q_t                    q_out,
	input  logic                                q_pop
);

	wfa_pkg::win_type_t                  type_q;
	logic [wfa_pkg::LenBits-1:0]         len_q;
	logic [wfa_pkg::IndexBits-1:0]       idx_q;
	wfa_pkg::item_t                      mem_q [wfa_pkg::ItemDepth];
	logic [wfa_pkg::ItemPtrBits-1:0]     wr_ptr_q;
	logic [wfa_pkg::ItemPtrBits-1:0]     rd_ptr_q;
	logic [wfa_pkg::ItemCntBits-1:0]     cnt_q;

	logic [wfa_pkg::IndexBits-1:0]       d_c;
	logic [wfa_pkg::IndexBits-1:0]       k_c;
	logic                                last_c;
	logic                                accept;
	logic                                pop_ok;
	wfa_pkg::item_t                      new_item;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= wfa_pkg::WinBoxcar;
			len_q  <= wfa_pkg::LengthReset;
		end else if (cfg_we) begin
			if (cfg_index == wfa_pkg::RegWindowType) begin
				type_q <= wfa_pkg::win_type_t'(cfg_data[1:0]);
			end else if (cfg_index == wfa_pkg::RegWindowLength) begin
				len_q <= cfg_data[wfa_pkg::LenBits-1:0];
			end
		end
	end

	// Frame length clamped to its legal range, as the last index n-1.
	always_comb begin
		if (len_q < wfa_pkg::LenBits'(2)) begin
			d_c = wfa_pkg::IndexBits'(1);
		end else if (len_q > wfa_pkg::LenBits'(wfa_pkg::MaxLength)) begin
			d_c = wfa_pkg::IndexBits'(wfa_pkg::MaxLength - 1);
		end else begin
			d_c = wfa_pkg::IndexBits'(len_q - wfa_pkg::LenBits'(1));
		end
	end

	// An index left beyond the frame by a shorter length is pulled to its end.
	assign k_c    = (idx_q > d_c) ? d_c : idx_q;
	assign last_c = (k_c == d_c);

	assign full   = (cnt_q == wfa_pkg::ItemCntBits'(wfa_pkg::ItemDepth));
	assign accept = push && !full;
	assign pop_ok = q_pop && (cnt_q != '0);

	always_comb begin
		new_item.sample = sample;
		new_item.k      = k_c;
		new_item.d      = d_c;
		new_item.last   = last_c;
		new_item.wtype  = type_q;
	end

	// Running index of the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= last_c ? '0 : k_c + wfa_pkg::IndexBits'(1);
		end
	end

	// Item queue storage.
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Item queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + wfa_pkg::ItemPtrBits'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + wfa_pkg::ItemPtrBits'(1);
			end
			unique case ({accept, pop_ok})
				2'b10:   cnt_q <= cnt_q + wfa_pkg::ItemCntBits'(1);
				2'b01:   cnt_q <= cnt_q - wfa_pkg::ItemCntBits'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign q_out.avail = (cnt_q != '0);
	assign q_out.item  = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
	// The fill count never passes the queue depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= wfa_pkg::ItemCntBits'(wfa_pkg::ItemDepth))
		else $error("item queue count beyond depth");

	// The index restarts after the last item of a frame.
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_c |=> idx_q == '0)
		else $error("index did not wrap after last item");

	// The back part never takes an item from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != '0)
		else $error("item popped from empty queue");
`endif

endmodule

// ----- rtl/wfa_back.sv -----
// Back part of the window block: phase divider, cosine ROM, coefficient and
// product arithmetic, and the result queue. Depends on wfa_pkg.
module wfa_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wfa_pkg::item_q_t                      q_in,
	output logic                                  q_pop,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [wfa_pkg::SampleBits-1:0] windowed_sample,
	output logic [wfa_pkg::CoefBits-1:0]          coefficient,
	output logic                                  last
);

	localparam wfa_pkg::cos_rom_t CosRom = wfa_pkg::build_cos_rom();

	typedef enum logic [2:0] {
		StIdle,
		StDivide,
		StLookup,
		StMultiply,
		StCoeff,
		StScale,
		StPush
	} state_t;

	state_t                                  state_q;
	wfa_pkg::item_t                          item_q;
	logic [wfa_pkg::IndexBits-1:0]           rem_q;
	logic [wfa_pkg::PhaseBits-1:0]           quot_q;
	logic [3:0]                              step_q;
	logic                                    neg1_q;
	logic                                    neg2_q;
	logic [wfa_pkg::CoefBits-1:0]            mag1_q;
	logic [wfa_pkg::CoefBits-1:0]            mag2_q;
	logic signed [wfa_pkg::AccBits-1:0]      prod1_q;
	logic signed [wfa_pkg::AccBits-1:0]      prod2_q;
	logic [wfa_pkg::CoefBits-1:0]            coef_q;
	logic signed [wfa_pkg::ScaledBits-1:0]   scaled_q;

	wfa_pkg::result_t                        res_mem_q [wfa_pkg::ResDepth];
	logic [wfa_pkg::ResPtrBits-1:0]          res_wr_q;
	logic [wfa_pkg::ResPtrBits-1:0]          res_rd_q;
	logic [wfa_pkg::ResCntBits-1:0]          res_cnt_q;

	logic [wfa_pkg::IndexBits:0]             dbl_c;
	logic                                    ge_c;
	logic [wfa_pkg::IndexBits-1:0]           nrem_c;
	logic [wfa_pkg::PhaseBits-1:0]           p2_c;
	logic [wfa_pkg::RomAddrBits-1:0]         addr1_c;
	logic [wfa_pkg::RomAddrBits-1:0]         addr2_c;
	logic signed [wfa_pkg::CoefBits:0]       c1_c;
	logic signed [wfa_pkg::CoefBits:0]       c2_c;
	logic signed [wfa_pkg::AccBits-1:0]      acc_c;
	logic signed [wfa_pkg::AccBits-1:0]      acc_sh_c;
	logic [wfa_pkg::CoefBits-1:0]            coef_c;
	logic [wfa_pkg::ScaledBits-1:0]          mag_c;
	logic [wfa_pkg::CoefBits:0]              rnd_c;
	logic signed [wfa_pkg::CoefBits+1:0]     res_c;
	wfa_pkg::result_t                        result_c;
	logic                                    res_full;
	logic                                    res_push;
	logic                                    res_pop;

	// Address into the quarter-wave table for a full-circle phase.
	function automatic logic [wfa_pkg::RomAddrBits-1:0] cos_addr(
		logic [wfa_pkg::PhaseBits-1:0] p);
		logic [wfa_pkg::RomAddrBits-1:0] r;
		r = wfa_pkg::RomAddrBits'(p[wfa_pkg::PhaseBits-3:0]);
		if (p[wfa_pkg::PhaseBits-2]) begin
			return wfa_pkg::RomAddrBits'(wfa_pkg::QuarterLen) - r;
		end
		return r;
	endfunction

	// One restoring step of the phase division k * 2^12 / d.
	assign dbl_c  = {rem_q, 1'b0};
	assign ge_c   = (dbl_c >= {1'b0, item_q.d});
	assign nrem_c = ge_c ? wfa_pkg::IndexBits'(dbl_c - {1'b0, item_q.d})
		: wfa_pkg::IndexBits'(dbl_c);

	// Table addresses for the phase and for twice the phase.
	assign p2_c    = {quot_q[wfa_pkg::PhaseBits-2:0], 1'b0};
	assign addr1_c = cos_addr(quot_q);
	assign addr2_c = cos_addr(p2_c);

	// Signed cosines from the table magnitudes.
	assign c1_c = neg1_q ? -$signed({1'b0, mag1_q}) : $signed({1'b0, mag1_q});
	assign c2_c = neg2_q ? -$signed({1'b0, mag2_q}) : $signed({1'b0, mag2_q});

	// Coefficient: constant term minus and plus the cosine terms, rounded, clamped.
	always_comb begin
		acc_c = ($signed({{(wfa_pkg::AccBits-wfa_pkg::CoefBits){1'b0}},
			wfa_pkg::coef_a0(item_q.wtype)}) <<< 15)
			- prod1_q + prod2_q + wfa_pkg::AccBits'(wfa_pkg::RoundHalf);
		acc_sh_c = acc_c >>> 15;
		if (acc_c < 0) begin
			coef_c = '0;
		end else if (acc_sh_c > wfa_pkg::AccBits'(wfa_pkg::CoefOne)) begin
			coef_c = wfa_pkg::CoefBits'(wfa_pkg::CoefOne);
		end else begin
			coef_c = acc_sh_c[wfa_pkg::CoefBits-1:0];
		end
	end

	// Scaled sample rounded half away from zero and saturated.
	always_comb begin
		mag_c = (scaled_q < 0) ? wfa_pkg::ScaledBits'(-scaled_q)
			: wfa_pkg::ScaledBits'(scaled_q);
		rnd_c = wfa_pkg::CoefBits'(1) == 0 ? '0
			: (wfa_pkg::CoefBits+1)'((mag_c + wfa_pkg::ScaledBits'(wfa_pkg::RoundHalf)) >> 15);
		res_c = (scaled_q < 0) ? -$signed({1'b0, rnd_c}) : $signed({1'b0, rnd_c});
		if (res_c > $signed((wfa_pkg::CoefBits+2)'(32767))) begin
			result_c.windowed_sample = 16'sd32767;
		end else begin
			result_c.windowed_sample = res_c[wfa_pkg::SampleBits-1:0];
		end
		result_c.coefficient = coef_q;
		result_c.last        = item_q.last;
	end

	assign q_pop    = (state_q == StIdle) && q_in.avail;
	assign res_full = (res_cnt_q == wfa_pkg::ResCntBits'(wfa_pkg::ResDepth));
	assign res_push = (state_q == StPush) && !res_full;
	assign res_pop  = pop && !empty;

	// Cosine table reads, two per lookup.
	always_ff @(posedge clk) begin
		if (state_q == StLookup) begin
			mag1_q <= CosRom[addr1_c];
			mag2_q <= CosRom[addr2_c];
		end
	end

	// Sequencer for one item: divide, look up, multiply, combine, scale, deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			step_q   <= '0;
			item_q   <= '0;
			rem_q    <= '0;
			quot_q   <= '0;
			neg1_q   <= 1'b0;
			neg2_q   <= 1'b0;
			prod1_q  <= '0;
			prod2_q  <= '0;
			coef_q   <= '0;
			scaled_q <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (q_in.avail) begin
						item_q  <= q_in.item;
						rem_q   <= (q_in.item.k == q_in.item.d) ? '0 : q_in.item.k;
						quot_q  <= '0;
						step_q  <= '0;
						state_q <= StDivide;
					end
				end
				StDivide: begin
					rem_q  <= nrem_c;
					quot_q <= {quot_q[wfa_pkg::PhaseBits-2:0], ge_c};
					step_q <= step_q + 4'd1;
					if (step_q == 4'(wfa_pkg::PhaseBits - 1)) begin
						state_q <= StLookup;
					end
				end
				StLookup: begin
					neg1_q  <= quot_q[wfa_pkg::PhaseBits-1] ^ quot_q[wfa_pkg::PhaseBits-2];
					neg2_q  <= p2_c[wfa_pkg::PhaseBits-1] ^ p2_c[wfa_pkg::PhaseBits-2];
					state_q <= StMultiply;
				end
				StMultiply: begin
					prod1_q <= $signed({{(wfa_pkg::AccBits-wfa_pkg::CoefBits){1'b0}},
						wfa_pkg::coef_a1(item_q.wtype)})
						* $signed({{(wfa_pkg::AccBits-wfa_pkg::CoefBits-1){c1_c[wfa_pkg::CoefBits]}},
						c1_c});
					prod2_q <= $signed({{(wfa_pkg::AccBits-wfa_pkg::CoefBits){1'b0}},
						wfa_pkg::coef_a2(item_q.wtype)})
						* $signed({{(wfa_pkg::AccBits-wfa_pkg::CoefBits-1){c2_c[wfa_pkg::CoefBits]}},
						c2_c});
					state_q <= StCoeff;
				end
				StCoeff: begin
					coef_q  <= coef_c;
					state_q <= StScale;
				end
				StScale: begin
					scaled_q <= $signed({{(wfa_pkg::ScaledBits-wfa_pkg::SampleBits)
						{item_q.sample[wfa_pkg::SampleBits-1]}}, item_q.sample})
						* $signed({{(wfa_pkg::ScaledBits-wfa_pkg::CoefBits){1'b0}}, coef_q});
					state_q  <= StPush;
				end
				StPush: begin
					if (!res_full) begin
						state_q <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= result_c;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= res_wr_q + wfa_pkg::ResPtrBits'(1);
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + wfa_pkg::ResPtrBits'(1);
			end
			unique case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + wfa_pkg::ResCntBits'(1);
				2'b01:   res_cnt_q <= res_cnt_q - wfa_pkg::ResCntBits'(1);
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	assign empty           = (res_cnt_q == '0);
	assign windowed_sample = res_mem_q[res_rd_q].windowed_sample;
	assign coefficient     = res_mem_q[res_rd_q].coefficient;
	assign last            = res_mem_q[res_rd_q].last;

`ifndef SYNTHESIS
	// The division remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StDivide |-> rem_q < item_q.d)
		else $error("phase divider remainder out of range");

	// A coefficient about to be delivered is at most one.
	a_coef_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StPush |-> coef_q <= wfa_pkg::CoefBits'(wfa_pkg::CoefOne))
		else $error("coefficient above one");

	// The result queue never overfills.
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= wfa_pkg::ResCntBits'(wfa_pkg::ResDepth))
		else $error("result queue count beyond depth");

	// A new item is taken only after the previous one has been delivered.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == StDivide && step_q == '0)
		else $error("item taken while another is in progress");
`endif

endmodule
